// ===== src/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, operation, status and
// cell command codes, and the entry and chain control types.
// No dependencies; every other file of the block imports it.
package spq_pkg;

	localparam int CAPACITY  = 16;
	localparam int RANK_BITS = 8;
	localparam int VALUE_W   = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// operation codes
	localparam logic [1:0] OP_ENQUEUE  = 2'd0;
	localparam logic [1:0] OP_DEQUEUE  = 2'd1;
	localparam logic [1:0] OP_TRAVERSE = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_DELIVER = 2'd0;
	localparam logic [1:0] STAT_ACCEPT  = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	// commands broadcast to the row of cells
	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;
	localparam logic [1:0] CMD_ROTATE = 2'd3;

	typedef struct packed {
		logic [VALUE_W-1:0]   value;
		logic [RANK_BITS-1:0] rank;
	} entry_t;

	typedef struct packed {
		logic [1:0] cmd;
		entry_t     new_e;
		entry_t     head;
	} chain_ctl_t;

endpackage

// ===== src/spq_cmd_if.sv =====
// Command channel of the sorted priority queue: valid/ready plus one
// operation with its entry. Depends on spq_pkg.
interface spq_cmd_if
	import spq_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic [1:0]                  operation;
	logic signed [VALUE_W-1:0]   item_value;
	logic [RANK_BITS-1:0]        item_rank;

	modport source (output valid, operation, item_value, item_rank, input ready);
	modport sink   (input valid, operation, item_value, item_rank, output ready);
endinterface

// ===== src/spq_rsp_if.sv =====
// Response channel of the sorted priority queue: valid/ready plus status,
// delivered entry and end marker. Depends on spq_pkg.
interface spq_rsp_if
	import spq_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic signed [VALUE_W-1:0]   out_value;
	logic [RANK_BITS-1:0]        out_rank;
	logic                        last;

	modport source (output valid, status, out_value, out_rank, last, input ready);
	modport sink   (input valid, status, out_value, out_rank, last, output ready);
endinterface

// ===== src/spq_cell.sv =====
// One slot of the sorted row: holds an entry and its valid bit, and
// trades entries with its neighbours under the broadcast command. Uses spq_pkg.
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  entry_t     left_e,
	input  logic       left_v,
	input  logic       left_ins,
	input  entry_t     right_e,
	input  logic       right_v,
	output entry_t     e,
	output logic       v,
	output logic       ins
);

	entry_t e_q;
	logic   v_q;
	entry_t e_d;
	logic   v_d;

	// insertion point lies here or to the left: slot empty or rank strictly greater
	assign ins = !v_q || (e_q.rank > ctl.new_e.rank);

	// choose next contents
	always_comb begin
		e_d = e_q;
		v_d = v_q;
		case (ctl.cmd)
			CMD_INSERT: begin
				if (ins) begin
					if (!left_ins) begin
						e_d = ctl.new_e;
						v_d = 1'b1;
					end else begin
						e_d = left_e;
						v_d = left_v;
					end
				end
			end
			CMD_POP: begin
				e_d = right_e;
				v_d = right_v;
			end
			CMD_ROTATE: begin
				// the tail slot takes the front entry, the rest advance
				if (right_v) begin
					e_d = right_e;
				end else if (v_q) begin
					e_d = ctl.head;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		e_q <= e_d;
	end

	assign e = e_q;
	assign v = v_q;

endmodule

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue: a row of CAPACITY cells kept in ascending rank
// order, front at cell 0. Entries of equal rank leave in arrival order.
//
// Channels: cmd (sink) takes one operation per transaction: enqueue,
// dequeue or traverse; code 3 is taken and dropped with no response.
// rsp (source) returns the results from a registered output stage.
// Enqueue and dequeue: the row shifts at the accepting edge and the single
// response appears the next cycle. A new command is taken every cycle as
// long as the response register is free or drained.
// Traverse: one response per held entry, one per cycle unless rsp stalls,
// by rotating the row once per entry so that it ends in its original
// order; an empty queue gives one empty response. No command is taken
// until the last entry of a traverse has been loaded into the output stage.
// Enqueue on a full queue answers full and leaves the row unchanged.
// Reset empties the queue at once (cell valid bits and fill count clear).
// When rsp stalls, the response is held and cmd stops taking transactions.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	spq_cmd_if.sink         cmd,
	spq_rsp_if.source       rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WALK = 1'b1;

	logic                 state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     remain_q;

	logic                 rsp_valid_q;
	logic [1:0]           status_q;
	entry_t               out_e_q;
	logic                 last_q;

	chain_ctl_t           ctl;
	entry_t               cell_e   [CAPACITY];
	logic [CAPACITY-1:0]  cell_v;
	logic [CAPACITY-1:0]  cell_ins;

	logic                 out_free;
	logic                 acc;
	logic                 load;
	logic [1:0]           r_status;
	entry_t               r_e;
	logic                 r_last;
	logic                 empty;
	logic                 full;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && out_free;
	assign acc      = cmd.valid && cmd.ready;

	// decode the transaction or the next traverse step
	always_comb begin
		ctl.cmd         = CMD_HOLD;
		ctl.new_e.value = cmd.item_value;
		ctl.new_e.rank  = cmd.item_rank;
		ctl.head        = cell_e[0];
		load            = 1'b0;
		r_status        = STAT_EMPTY;
		r_e             = '0;
		r_last          = 1'b1;
		if (state_q == S_WALK) begin
			if (out_free) begin
				load     = 1'b1;
				r_status = STAT_DELIVER;
				r_e      = cell_e[0];
				r_last   = (remain_q == CNT_W'(1));
				ctl.cmd  = CMD_ROTATE;
			end
		end else if (acc) begin
			case (cmd.operation)
				OP_ENQUEUE: begin
					load = 1'b1;
					if (full) begin
						r_status = STAT_FULL;
					end else begin
						r_status = STAT_ACCEPT;
						ctl.cmd  = CMD_INSERT;
					end
				end
				OP_DEQUEUE: begin
					load = 1'b1;
					if (!empty) begin
						r_status = STAT_DELIVER;
						r_e      = cell_e[0];
						ctl.cmd  = CMD_POP;
					end
				end
				OP_TRAVERSE: begin
					load = 1'b1;
					if (!empty) begin
						r_status = STAT_DELIVER;
						r_e      = cell_e[0];
						r_last   = (count_q == CNT_W'(1));
						ctl.cmd  = CMD_ROTATE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// row of cells
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			entry_t l_e;
			logic   l_v;
			logic   l_ins;
			entry_t r_ne;
			logic   r_nv;
			if (i == 0) begin : g_first
				assign l_e   = '0;
				assign l_v   = 1'b0;
				assign l_ins = 1'b0;
			end else begin : g_mid
				assign l_e   = cell_e[i-1];
				assign l_v   = cell_v[i-1];
				assign l_ins = cell_ins[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign r_ne = '0;
				assign r_nv = 1'b0;
			end else begin : g_inner
				assign r_ne = cell_e[i+1];
				assign r_nv = cell_v[i+1];
			end
			spq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.left_e   (l_e),
				.left_v   (l_v),
				.left_ins (l_ins),
				.right_e  (r_ne),
				.right_v  (r_nv),
				.e        (cell_e[i]),
				.v        (cell_v[i]),
				.ins      (cell_ins[i])
			);
		end
	endgenerate

	// fill count and traverse sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			remain_q <= '0;
		end else begin
			if (ctl.cmd == CMD_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.cmd == CMD_POP) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (state_q == S_WALK) begin
				if (out_free) begin
					remain_q <= remain_q - CNT_W'(1);
					if (remain_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
			end else if (acc && cmd.operation == OP_TRAVERSE && count_q > CNT_W'(1)) begin
				state_q  <= S_WALK;
				remain_q <= count_q - CNT_W'(1);
			end
		end
	end

	// output stage: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= r_status;
			out_e_q  <= r_e;
			last_q   <= r_last;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.out_value = signed'(out_e_q.value);
	assign rsp.out_rank  = out_e_q.rank;
	assign rsp.last      = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_v) == int'(count_q))
		else $error("cell valid bits disagree with fill count");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_v + CAPACITY'(1)) & cell_v) == '0)
		else $error("valid cells not packed at the front");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == CMD_POP) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("dequeue did not drop the fill count");

	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (!cmd.ready && count_q > CNT_W'(1)))
		else $error("command taken during traverse");
`endif

endmodule

// ===== sim/sorted_priority_queue_tb.sv =====
// Self-checking testbench for sorted_priority_queue: a clocked driver and
// monitor around the block, with a built-in predictor of the sorted row.
// Depends on spq_pkg, spq_cmd_if, spq_rsp_if and the block itself.
module sorted_priority_queue_tb
	import spq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int RANDOM_ITEMS = 75;
	localparam int SQUEEZE_AT   = 45;
	localparam int SQUEEZE_LEN  = 120;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS  = 10;
	localparam int TIMEOUT_NS   = 3_000_000;

	typedef struct {
		logic [1:0]                op;
		logic signed [VALUE_W-1:0] value;
		logic [RANK_BITS-1:0]      rank;
		int unsigned               gap;
	} cmd_item_t;

	typedef struct {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] value;
		logic [RANK_BITS-1:0]      rank;
		logic                      last;
	} queue_answer_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_cmd_if cmd_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// predicted contents of the row, front at index 0
	entry_t rows [CAPACITY];
	int     held_count = 0;
	int     deepest = 0;
	int     full_answers = 0;
	int     empty_answers = 0;

	cmd_item_t     pending_cmds [$];
	queue_answer_t due_answers [$];

	int unsigned gap_left;
	int unsigned ready_wait;
	int unsigned squeeze_left;
	logic        squeeze_done;
	int          cmds_taken;
	int          answers_seen = 0;
	int          mismatches = 0;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic add_answer(input logic [1:0] status, input logic signed [VALUE_W-1:0] value,
			input logic [RANK_BITS-1:0] rank, input logic last);
		queue_answer_t a;
		a.status = status;
		a.value  = value;
		a.rank   = rank;
		a.last   = last;
		due_answers.push_back(a);
	endtask

	// work out the answers to one accepted command and update the row
	task automatic predict_answers(input logic [1:0] op, input logic signed [VALUE_W-1:0] value,
			input logic [RANK_BITS-1:0] rank);
		int slot;
		entry_t fresh;
		case (op)
			OP_ENQUEUE: begin
				if (held_count == CAPACITY) begin
					add_answer(STAT_FULL, '0, '0, 1'b1);
					full_answers++;
				end else begin
					// insert behind every entry of lower or equal rank
					slot = 0;
					while (slot < held_count && rows[slot].rank <= rank)
						slot++;
					for (int i = held_count; i > slot; i--)
						rows[i] = rows[i - 1];
					fresh.value = value;
					fresh.rank  = rank;
					rows[slot]  = fresh;
					held_count++;
					if (held_count > deepest)
						deepest = held_count;
					add_answer(STAT_ACCEPT, '0, '0, 1'b1);
				end
			end
			OP_DEQUEUE: begin
				if (held_count == 0) begin
					add_answer(STAT_EMPTY, '0, '0, 1'b1);
					empty_answers++;
				end else begin
					add_answer(STAT_DELIVER, rows[0].value, rows[0].rank, 1'b1);
					for (int i = 1; i < held_count; i++)
						rows[i - 1] = rows[i];
					held_count--;
				end
			end
			OP_TRAVERSE: begin
				if (held_count == 0) begin
					add_answer(STAT_EMPTY, '0, '0, 1'b1);
					empty_answers++;
				end else begin
					for (int i = 0; i < held_count; i++)
						add_answer(STAT_DELIVER, rows[i].value, rows[i].rank, i == held_count - 1);
				end
			end
			default: begin
				// unused code: dropped without an answer
			end
		endcase
	endtask

	// queue a command; every third band of fifteen goes without gaps
	task automatic add_cmd(input logic [1:0] op, input logic signed [VALUE_W-1:0] value,
			input logic [RANK_BITS-1:0] rank);
		cmd_item_t c;
		c.op    = op;
		c.value = value;
		c.rank  = rank;
		c.gap   = ((pending_cmds.size() / 15) % 3 == 2) ? 0 : $urandom_range(0, 10);
		pending_cmds.push_back(c);
	endtask

	// command driver: offer, hold until taken, then wait the drawn gap
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		cmd_item_t nxt;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			gap_left     <= 0;
			cmds_taken   <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_answers(cmd_ch.operation, cmd_ch.item_value, cmd_ch.item_rank);
				cmds_taken <= cmds_taken + 1;
			end
			if (cmd_ch.valid && !cmd_ch.ready) begin
				// hold the offered transaction
			end else if (gap_left != 0) begin
				cmd_ch.valid <= 1'b0;
				gap_left     <= gap_left - 1;
			end else if (pending_cmds.size() != 0) begin
				nxt = pending_cmds.pop_front();
				cmd_ch.valid      <= 1'b1;
				cmd_ch.operation  <= nxt.op;
				cmd_ch.item_value <= nxt.value;
				cmd_ch.item_rank  <= nxt.rank;
				gap_left          <= nxt.gap;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off once, partway through the random traffic
	always @(posedge clk or negedge arst_n) begin : squeeze_ctl
		if (!arst_n) begin
			squeeze_left <= 0;
			squeeze_done <= 1'b0;
		end else if (!squeeze_done && cmds_taken >= SQUEEZE_AT) begin
			squeeze_left <= SQUEEZE_LEN;
			squeeze_done <= 1'b1;
		end else if (squeeze_left != 0) begin
			squeeze_left <= squeeze_left - 1;
		end
	end

	// response monitor: compare each transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		queue_answer_t want;
		int unsigned   wait_next;
		logic          calm;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			ready_wait   <= 0;
		end else begin
			wait_next = ready_wait;
			if (rsp_ch.valid && rsp_ch.ready) begin
				answers_seen++;
				if (due_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected response status %0d value %0d",
							$realtime, rsp_ch.status, $signed(rsp_ch.out_value),
							" rank %0d last %0d", rsp_ch.out_rank, rsp_ch.last);
				end else begin
					want = due_answers.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.out_value !== want.value ||
							rsp_ch.out_rank !== want.rank || rsp_ch.last !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: mismatch: expected status %0d value %0d",
								$realtime, want.status, want.value,
								" rank %0d last %0d,", want.rank, want.last,
								" got status %0d value %0d", rsp_ch.status,
								$signed(rsp_ch.out_value),
								" rank %0d last %0d", rsp_ch.out_rank, rsp_ch.last);
					end
				end
				// draw the stall before the next transaction; some bands run flat out
				calm = ((answers_seen / 24) % 3) == 1;
				wait_next = calm ? 0 : $urandom_range(0, 10);
			end else if (wait_next != 0) begin
				wait_next--;
			end
			ready_wait   <= wait_next;
			rsp_ch.ready <= (wait_next == 0) && (squeeze_left == 0);
		end
	end

	// stimulus: directed corner cases, then random phases of traffic
	initial begin : stimulus
		int counted;
		int pick;
		int phase;
		int enq_share;
		logic narrow;
		logic [1:0] op;
		logic [RANK_BITS-1:0] rank;

		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.operation  = OP_ENQUEUE;
		cmd_ch.item_value = '0;
		cmd_ch.item_rank  = '0;
		rsp_ch.ready      = 1'b0;

		// empty queue: dequeue, traverse and the unused code
		add_cmd(OP_DEQUEUE, 32'sd5, 8'd9);
		add_cmd(OP_TRAVERSE, -32'sd1, 8'hFF);
		add_cmd(OP_UNUSED, 32'h5A5A_A5A5, 8'hA5);
		// extremes of value and rank, and a tie on rank zero
		add_cmd(OP_ENQUEUE, 32'h7FFF_FFFF, 8'd0);
		add_cmd(OP_ENQUEUE, 32'h8000_0000, 8'd255);
		add_cmd(OP_ENQUEUE, 32'sd0, 8'd128);
		add_cmd(OP_ENQUEUE, -32'sd1, 8'd0);
		add_cmd(OP_TRAVERSE, '0, '0);
		add_cmd(OP_DEQUEUE, '0, '0);
		// fill to capacity with some ties, then overflow it
		for (int i = 0; i < 13; i++)
			add_cmd(OP_ENQUEUE, $urandom, (i % 4 == 0) ? 8'd128 : 8'((i * 37) % 256));
		add_cmd(OP_ENQUEUE, 32'sd77, 8'd1);
		add_cmd(OP_TRAVERSE, '0, '0);
		add_cmd(OP_UNUSED, $urandom, RANK_BITS'($urandom_range(0, 255)));

		// random phases: fill, drain, fill with close ranks, mixed
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			phase = (counted / 20) % 4;
			case (phase)
				0: enq_share = 70;
				1: enq_share = 15;
				2: enq_share = 70;
				default: enq_share = 44;
			endcase
			narrow = (phase == 2) || ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = OP_UNUSED;
			else if (pick < 12)
				op = OP_TRAVERSE;
			else if (pick < 12 + enq_share)
				op = OP_ENQUEUE;
			else
				op = OP_DEQUEUE;
			rank = narrow ? RANK_BITS'($urandom_range(0, 3)) : RANK_BITS'($urandom_range(0, 255));
			add_cmd(op, $urandom, rank);
			if (op != OP_UNUSED)
				counted++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every command to be taken and every answer to arrive
		while (pending_cmds.size() != 0 || cmd_ch.valid || due_answers.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d commands and %0d responses: %0d full and %0d empty answers",
			cmds_taken, answers_seen, full_answers, empty_answers);
		$display("deepest queue %0d of %0d, mismatches %0d", deepest, CAPACITY, mismatches);
		if (mismatches == 0 && due_answers.size() == 0) begin
			$display("sorted_priority_queue_tb: done, clean");
		end else begin
			$display("sorted_priority_queue_tb: done, errors");
		end
		$finish;
	end

	// give up if the run hangs
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("timeout with %0d responses still due", due_answers.size());
		$display("sorted_priority_queue_tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_cmd_if.sv
src/spq_rsp_if.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
